// ===== rtl/core/rkr_pkg.sv =====
// Package for the reference-counted key registry: sizes, request and status
// codes, and the structs that travel on the ports and along the cell chain.
// No dependencies.
`default_nettype none

package rkr_pkg;

   localparam int ENTRIES    = 256;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int KEY_BITS   = 64;
   localparam int OWNER_BITS = 16;
   localparam int COUNT_BITS = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      REQ_LOOKUP     = 2'd0,
      REQ_REGISTER   = 2'd1,
      REQ_UNREGISTER = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2,
      ST_ZERO = 2'd3
   } status_code_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [KEY_BITS-1:0]   key;
      logic [OWNER_BITS-1:0] owner;
   } req_item_type;

   typedef struct packed {
      status_code_type       status;
      logic [OWNER_BITS-1:0] owner_out;
      logic [COUNT_BITS-1:0] count_out;
   } rsp_item_type;

   // request as it walks the chain, one cell per cycle
   typedef struct packed {
      logic                  active;
      logic                  zero;
      logic [1:0]            req_type;
      logic [KEY_BITS-1:0]   key;
      logic [OWNER_BITS-1:0] owner;
      logic                  hit;
      logic [OWNER_BITS-1:0] res_owner;
      logic [COUNT_BITS-1:0] res_count;
      logic                  free_found;
      logic [IDX_BITS-1:0]   free_idx;
   } probe_type;

   // slot fill broadcast from the tail of the chain
   typedef struct packed {
      logic                  we;
      logic [IDX_BITS-1:0]   idx;
      logic [KEY_BITS-1:0]   key;
      logic [OWNER_BITS-1:0] owner;
   } alloc_type;

endpackage

`default_nettype wire

// ===== rtl/core/rkr_cell.sv =====
// One table slot of the key registry: valid mark, key, owner and count,
// plus one stage of the probe chain. Depends on rkr_pkg.
`default_nettype none

module rkr_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rkr_pkg::IDX_BITS-1:0]   cell_index,
   input  rkr_pkg::probe_type             probe_in,
   input  rkr_pkg::alloc_type             alloc,
   output rkr_pkg::probe_type             probe_out
);
   import rkr_pkg::*;

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   probe_type             probe_ff, probe_in_nx;
   logic                  match;
   logic [COUNT_BITS-1:0] cnt;

   always_comb begin
      valid_in    = valid_ff;
      key_in      = key_ff;
      owner_in    = owner_ff;
      count_in    = count_ff;
      probe_in_nx = probe_in;
      cnt         = count_ff;
      match       = probe_in.active && !probe_in.zero && !probe_in.hit && valid_ff &&
                    (key_ff == probe_in.key);

      if (match) begin
         case (probe_in.req_type)
            REQ_LOOKUP: begin
               probe_in_nx.hit       = 1'b1;
               probe_in_nx.res_owner = owner_ff;
               probe_in_nx.res_count = count_ff;
            end
            REQ_REGISTER: begin
               cnt = (count_ff == COUNT_MAX) ? count_ff : COUNT_BITS'(count_ff + 1'b1);
               count_in              = cnt;
               probe_in_nx.hit       = 1'b1;
               probe_in_nx.res_owner = owner_ff;
               probe_in_nx.res_count = cnt;
            end
            REQ_UNREGISTER: begin
               cnt = (count_ff == '0) ? '0 : COUNT_BITS'(count_ff - 1'b1);
               count_in              = cnt;
               probe_in_nx.hit       = 1'b1;
               probe_in_nx.res_owner = owner_ff;
               probe_in_nx.res_count = cnt;
               if (cnt == '0) begin
                  valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      // remember the lowest free slot in case a register misses
      if (probe_in.active && !valid_ff && !probe_in.free_found) begin
         probe_in_nx.free_found = 1'b1;
         probe_in_nx.free_idx   = cell_index;
      end

      if (alloc.we && (alloc.idx == cell_index)) begin
         valid_in = 1'b1;
         key_in   = alloc.key;
         owner_in = alloc.owner;
         count_in = COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         probe_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         probe_ff <= probe_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      owner_ff <= owner_in;
      count_ff <= count_in;
   end

   assign probe_out = probe_ff;

endmodule

`default_nettype wire

// ===== rtl/core/refcounted_key_registry_core.sv =====
// Top level of the reference-counted key registry: input register, chain of
// slot cells, slot fill and result register. Depends on rkr_pkg, rkr_cell.
//
// Usage:
//   Request channel: drive req (type, key, owner) and raise start; the item
//   is taken at a rising edge where start is high and busy is low. busy then
//   stays high until the result goes out.
//   Result channel: rsp_valid is high for exactly one cycle with rsp; the
//   receiver must take it then, it cannot stall the block.
//   Each item walks a chain of ENTRIES slot cells, one cell per cycle, from the
//   input register through the cells to the result register; busy falls in
//   the same cycle as the result strobe, and no new item is taken until then.
//   A register that misses fills the lowest free slot seen along the chain,
//   written from the tail as the result is produced.
//   A zero key is ignored with status zero-key; an unused request type
//   reports not found.
//   Reset (synchronous, active high) clears every valid mark, the chain and
//   busy; keys, owners and counts are not cleared.
`default_nettype none

module refcounted_key_registry_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rkr_pkg::req_item_type req,
   output logic                  rsp_valid,
   output rkr_pkg::rsp_item_type rsp
);
   import rkr_pkg::*;

   logic         busy_ff, busy_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   probe_type    head_ff, head_in;
   probe_type    chain [ENTRIES];
   probe_type    tail;
   alloc_type    alloc;
   logic         accept;

   assign accept = start && !busy_ff;

   always_comb begin
      head_in        = head_ff;
      head_in.active = 1'b0;
      if (accept) begin
         head_in.active     = 1'b1;
         head_in.zero       = (req.key == '0);
         head_in.req_type   = req.req_type;
         head_in.key        = req.key;
         head_in.owner      = req.owner;
         head_in.hit        = 1'b0;
         head_in.res_owner  = '0;
         head_in.res_count  = '0;
         head_in.free_found = 1'b0;
         head_in.free_idx   = '0;
      end
   end

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         if (g == 0) begin : g_first
            rkr_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .cell_index (IDX_BITS'(g)),
               .probe_in   (head_ff),
               .alloc      (alloc),
               .probe_out  (chain[g])
            );
         end else begin : g_rest
            rkr_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .cell_index (IDX_BITS'(g)),
               .probe_in   (chain[g-1]),
               .alloc      (alloc),
               .probe_out  (chain[g])
            );
         end
      end
   endgenerate

   assign tail = chain[ENTRIES-1];

   // resolve the item at the end of the chain
   always_comb begin
      alloc.we     = 1'b0;
      alloc.idx    = tail.free_idx;
      alloc.key    = tail.key;
      alloc.owner  = tail.owner;
      rsp_in       = rsp_ff;
      rsp_valid_in = tail.active;
      if (tail.active) begin
         rsp_in.status    = ST_MISS;
         rsp_in.owner_out = '0;
         rsp_in.count_out = '0;
         if (tail.zero) begin
            rsp_in.status = ST_ZERO;
         end else if (tail.hit) begin
            rsp_in.status    = ST_OK;
            rsp_in.owner_out = tail.res_owner;
            rsp_in.count_out = tail.res_count;
         end else if (tail.req_type == REQ_REGISTER) begin
            if (tail.free_found) begin
               alloc.we         = 1'b1;
               rsp_in.status    = ST_OK;
               rsp_in.owner_out = tail.owner;
               rsp_in.count_out = COUNT_BITS'(1);
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail.active) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         head_ff.active <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not raised after accepted item");

   a_tail_busy: assert property (@(posedge clock) disable iff (reset)
      tail.active |-> busy_ff)
      else $error("item at chain tail while not busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("busy still high with result strobe");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held more than one cycle");

   a_alloc_miss: assert property (@(posedge clock) disable iff (reset)
      alloc.we |-> (!tail.hit && !tail.zero && (tail.req_type == REQ_REGISTER)))
      else $error("slot fill without a register miss");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for refcounted_key_registry_core: directed and random lookup,
// register and unregister items checked against an in-bench table predictor.
// Depends on rkr_pkg and the core RTL.

module tb_top;
   import rkr_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int QUIET_FIRST = 300;   // from this issue count up to QUIET_LAST, items are issued with no idling
   localparam int QUIET_LAST  = 420;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req   = '0;
   logic         rsp_valid;
   rsp_item_type rsp;

   refcounted_key_registry_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // predicted table contents
   bit                    slot_valid [ENTRIES];
   logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
   logic [OWNER_BITS-1:0] slot_owner [ENTRIES];
   logic [COUNT_BITS-1:0] slot_count [ENTRIES];

   req_item_type request_q[$];
   rsp_item_type reply_q[$];
   int           issued     = 0;
   int           accepted   = 0;
   int           fail_count = 0;
   int           status_seen[4];
   int           cycle_count = 0;

   function automatic rsp_item_type apply_request(req_item_type r);
      rsp_item_type o;
      int           hit;
      int           free_slot;
      o.status    = ST_MISS;
      o.owner_out = '0;
      o.count_out = '0;
      hit         = -1;
      free_slot   = -1;
      // walk downward so the lowest index wins
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (slot_valid[i] && slot_key[i] == r.key)
            hit = i;
         if (!slot_valid[i])
            free_slot = i;
      end
      if (r.key == '0) begin
         o.status = ST_ZERO;
      end else begin
         case (r.req_type)
            REQ_LOOKUP: begin
               if (hit >= 0) begin
                  o.status    = ST_OK;
                  o.owner_out = slot_owner[hit];
                  o.count_out = slot_count[hit];
               end
            end
            REQ_REGISTER: begin
               if (hit >= 0) begin
                  if (slot_count[hit] != COUNT_MAX)
                     slot_count[hit] = slot_count[hit] + 1'b1;
                  o.status    = ST_OK;
                  o.owner_out = slot_owner[hit];
                  o.count_out = slot_count[hit];
               end else if (free_slot >= 0) begin
                  slot_valid[free_slot] = 1'b1;
                  slot_key[free_slot]   = r.key;
                  slot_owner[free_slot] = r.owner;
                  slot_count[free_slot] = COUNT_BITS'(1);
                  o.status    = ST_OK;
                  o.owner_out = r.owner;
                  o.count_out = COUNT_BITS'(1);
               end else begin
                  o.status = ST_FULL;
               end
            end
            REQ_UNREGISTER: begin
               if (hit >= 0) begin
                  if (slot_count[hit] != '0)
                     slot_count[hit] = slot_count[hit] - 1'b1;
                  o.status    = ST_OK;
                  o.owner_out = slot_owner[hit];
                  o.count_out = slot_count[hit];
                  if (slot_count[hit] == '0)
                     slot_valid[hit] = 1'b0;
               end
            end
            default: ;
         endcase
      end
      return o;
   endfunction

   // driver: one item on the port at a time, random idle cycles between items outside the quiet window
   always @(negedge clock) begin
      logic         next_start;
      req_item_type next_req;
      bit           idle;
      next_start = start;
      next_req   = req;
      if (!reset) begin
         if (start && accepted == issued)
            next_start = 1'b0;
         if (!next_start && request_q.size() != 0) begin
            idle = (issued < QUIET_FIRST || issued >= QUIET_LAST) &&
                   ($urandom_range(99) < 17);
            if (!idle) begin
               next_req   = request_q.pop_front();
               next_start = 1'b1;
               issued++;
            end
         end
         start <= next_start;
         req   <= next_req;
      end
   end

   // monitor: check the result first, then predict a newly taken item
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (rsp_valid) begin
            status_seen[rsp.status]++;
            if (reply_q.size() == 0) begin
               $error("result with nothing expected: status %0d owner_out %0h count_out %0d",
                      rsp.status, rsp.owner_out, rsp.count_out);
               fail_count++;
            end else begin
               want = reply_q.pop_front();
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  fail_count++;
               end
               if (rsp.owner_out !== want.owner_out) begin
                  $error("owner_out: expected %0h, got %0h", want.owner_out, rsp.owner_out);
                  fail_count++;
               end
               if (rsp.count_out !== want.count_out) begin
                  $error("count_out: expected %0d, got %0d", want.count_out, rsp.count_out);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            reply_q.push_back(apply_request(req));
            accepted++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items taken", cycle_count, accepted);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_req(req_code_type kind, logic [KEY_BITS-1:0] k,
                           logic [OWNER_BITS-1:0] own);
      req_item_type r;
      r.req_type = kind;
      r.key      = k;
      r.owner    = own;
      request_q.push_back(r);
   endtask

   task automatic push_raw(logic [1:0] kind, logic [KEY_BITS-1:0] k);
      req_item_type r;
      r.req_type = kind;
      r.key      = k;
      r.owner    = OWNER_BITS'($urandom_range(16'hffff));
      request_q.push_back(r);
   endtask

   function automatic logic [KEY_BITS-1:0] fresh_key();
      logic [KEY_BITS-1:0] k;
      k = {$urandom, $urandom};
      if (k == '0)
         k = 64'h1;
      return k;
   endfunction

   function automatic logic [OWNER_BITS-1:0] any_owner();
      return OWNER_BITS'($urandom_range(16'hffff));
   endfunction

   logic [KEY_BITS-1:0] key_pool[40];
   logic [KEY_BITS-1:0] fill_keys[$];

   initial begin
      logic [KEY_BITS-1:0] k;
      int                  pick;
      logic [1:0]          unused_type;
      unused_type = 2'd3;

      // directed items
      push_req(REQ_LOOKUP,     64'hffff_ffff_ffff_ffff, 16'h0000);
      push_req(REQ_LOOKUP,     64'h0,                   16'h1234);
      push_req(REQ_REGISTER,   64'h0,                   16'hffff);
      push_req(REQ_UNREGISTER, 64'h0,                   16'h0000);
      push_raw(unused_type,    64'h0);
      push_raw(unused_type,    64'h5555_aaaa_5555_aaaa);
      push_req(REQ_REGISTER,   64'hffff_ffff_ffff_ffff, 16'hffff);
      push_req(REQ_REGISTER,   64'h0000_0000_0000_0001, 16'h0000);
      push_req(REQ_REGISTER,   64'hffff_ffff_ffff_ffff, 16'h0001);  // owner kept
      push_req(REQ_LOOKUP,     64'hffff_ffff_ffff_ffff, 16'h0000);
      push_raw(unused_type,    64'hffff_ffff_ffff_ffff);
      push_req(REQ_UNREGISTER, 64'hffff_ffff_ffff_ffff, 16'h0000);
      push_req(REQ_UNREGISTER, 64'hffff_ffff_ffff_ffff, 16'h0000);  // freed
      push_req(REQ_LOOKUP,     64'hffff_ffff_ffff_ffff, 16'h0000);
      push_req(REQ_UNREGISTER, 64'hffff_ffff_ffff_ffff, 16'h0000);
      push_req(REQ_REGISTER,   64'h8000_0000_0000_0000, 16'h8000);  // lowest free slot
      push_req(REQ_LOOKUP,     64'h0000_0000_0000_0001, 16'h0000);
      push_req(REQ_UNREGISTER, 64'h0000_0000_0000_0001, 16'h0000);
      push_req(REQ_LOOKUP,     64'h8000_0000_0000_0000, 16'h0000);
      push_req(REQ_UNREGISTER, 64'h8000_0000_0000_0000, 16'h0000);

      // churn over a small key set, so hits and repeated counts are common
      foreach (key_pool[i])
         key_pool[i] = fresh_key();
      repeat (200) begin
         pick = $urandom_range(99);
         k    = key_pool[$urandom_range(39)];
         if (pick < 45)
            push_req(REQ_REGISTER, k, any_owner());
         else if (pick < 70)
            push_req(REQ_UNREGISTER, k, any_owner());
         else if (pick < 90)
            push_req(REQ_LOOKUP, k, any_owner());
         else if (pick < 94)
            push_raw(2'($urandom_range(3)), 64'h0);
         else if (pick < 97)
            push_raw(unused_type, k);
         else
            push_req(REQ_LOOKUP, fresh_key(), any_owner());
      end

      // fill the table past capacity
      repeat (270) begin
         k = fresh_key();
         fill_keys.push_back(k);
         push_req(REQ_REGISTER, k, any_owner());
         if ($urandom_range(9) == 0)
            push_req(REQ_LOOKUP, fill_keys[$urandom_range(fill_keys.size() - 1)],
                     any_owner());
      end

      // run near full: frees, refills of the lowest hole, full reports
      repeat (250) begin
         pick = $urandom_range(99);
         k    = fill_keys[$urandom_range(fill_keys.size() - 1)];
         if (pick < 35) begin
            push_req(REQ_UNREGISTER, k, any_owner());
         end else if (pick < 70) begin
            k = fresh_key();
            fill_keys.push_back(k);
            push_req(REQ_REGISTER, k, any_owner());
         end else if (pick < 82) begin
            push_req(REQ_REGISTER, k, any_owner());
         end else if (pick < 95) begin
            push_req(REQ_LOOKUP, k, any_owner());
         end else begin
            push_raw(2'($urandom_range(3)), $urandom_range(1) ? 64'h0 : k);
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (request_q.size() != 0 || start || reply_q.size() != 0)
         @(negedge clock);
      // a stray result would show up within one chain pass
      repeat (ENTRIES + 8) @(posedge clock);

      $display("%0d items taken in %0d cycles", accepted, cycle_count);
      $display("results: ok %0d, not found %0d, table full %0d, zero key %0d",
               status_seen[ST_OK], status_seen[ST_MISS], status_seen[ST_FULL],
               status_seen[ST_ZERO]);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/rkr_pkg.sv
rtl/core/rkr_cell.sv
rtl/core/refcounted_key_registry_core.sv
test/tb_top.sv
